// ===== sv/lsc_pkg.sv =====
`timescale 1ns / 1ps
package lsc_pkg;

  localparam int FEATURES     = 8;
  localparam int HIDDEN_UNITS = 8;
  localparam int MAX_REPORT   = 8;
  localparam int REPORT       = (HIDDEN_UNITS < MAX_REPORT) ? HIDDEN_UNITS : MAX_REPORT;

  localparam int WADDR_W = $clog2(4 * FEATURES * HIDDEN_UNITS);
  localparam int BADDR_W = $clog2(4 * HIDDEN_UNITS);
  localparam int FIDX_W  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int UIDX_W  = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int KCNT_W  = $clog2(FEATURES + 1);
  localparam int ACC_W   = 38;

  localparam logic [15:0] SCALE_RESET = 16'd655;

  localparam logic [1:0] REQ_WEIGHT  = 2'd0;
  localparam logic [1:0] REQ_BIAS    = 2'd1;
  localparam logic [1:0] REQ_FEATURE = 2'd2;

  localparam logic [1:0] GATE_FORGET = 2'd0;
  localparam logic [1:0] GATE_INPUT  = 2'd1;
  localparam logic [1:0] GATE_CAND   = 2'd2;
  localparam logic [1:0] GATE_OUTPUT = 2'd3;

  typedef struct packed {
    logic valid;   // a term arrives with this beat of read data
    logic clr;     // clear the accumulator
  } mac_ctrl_t;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) r = 16'sh7fff;
    else if (v < -40'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // PLAN piecewise-linear sigmoid, Q.12 in and out
  function automatic logic signed [13:0] sigmoid_q12(input logic signed [17:0] x);
    logic [17:0] a;
    logic [13:0] y;
    a = x[17] ? 18'(-x) : 18'(x);
    if (a >= 18'd20480) y = 14'd4096;
    else if (a >= 18'd9728) y = 14'(a >> 5) + 14'd3456;
    else if (a >= 18'd4096) y = 14'(a >> 3) + 14'd2560;
    else y = 14'(a >> 2) + 14'd2048;
    if (x[17]) y = 14'd4096 - y;
    return $signed(y);
  endfunction

  function automatic logic signed [13:0] tanh_q12(input logic signed [15:0] x);
    logic signed [13:0] s;
    logic signed [14:0] t;
    s = sigmoid_q12($signed({x[15], x, 1'b0}));
    t = $signed({s, 1'b0}) - 15'sd4096;
    return t[13:0];
  endfunction

endpackage

// ===== sv/lstm_cell_step.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake            | payload
// in      | in  | in_tvalid/in_tready  | tdata, tuser, tlast
// out     | out | out_tvalid/out_tready| tdata, tlast
// cfg     | in  | cfg_valid/cfg_ready  | cfg_data = weight_scale
// Each load beat is written to its store when accepted. A step runs per unit 4 gates of
// FEATURES+1 terms through one pipelined multiply-accumulate and then a cell update in
// the states S_CMUL, S_CADD, S_HMUL and S_EMIT.
// Input is held off during a step; a stalled result beat stalls the sequencer.
// Synchronous active-low reset clears hidden and cell state and reloads the scale default.
module lstm_cell_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // feature_index[2:0], unit_index[5:3], data_value[21:6]
  input  logic [3:0]  in_tuser,   // req_type[1:0], gate_select[3:2]
  input  logic        in_tlast,   // last_feature
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // hidden_unit[2:0], hidden_out[18:3], cell_out[34:19]
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import lsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_DRAIN, S_GATE, S_CMUL, S_CADD, S_HMUL, S_EMIT
  } state_t;

  state_t state_r;
  logic [15:0] scale_r;
  logic [1:0]  g_r;
  logic [KCNT_W-1:0] k_r;
  logic [UIDX_W-1:0] j_r;

  logic signed [15:0] wmem [4*FEATURES*HIDDEN_UNITS];
  logic signed [15:0] bmem [4*HIDDEN_UNITS];
  logic signed [15:0] fbuf [FEATURES];
  logic signed [15:0] wq_r, bq_r;
  logic               v1_r, bias1_r;
  logic signed [16:0] x1_r;

  logic signed [13:0] f_r, i_r, ct_r, o_r;
  logic signed [29:0] m_r;
  logic signed [15:0] cnew_r;
  logic signed [27:0] hm_r;

  logic        out_tvalid_r, out_tlast_r;
  logic [2:0]  out_unit_r;
  logic signed [15:0] out_h_r, out_c_r;

  logic [1:0]  in_req, in_gate;
  logic [2:0]  in_feat, in_unit;
  logic signed [15:0] in_data;
  logic        in_acc;

  assign in_req  = in_tuser[1:0];
  assign in_gate = in_tuser[3:2];
  assign in_feat = in_tdata[2:0];
  assign in_unit = in_tdata[5:3];
  assign in_data = $signed(in_tdata[21:6]);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc  = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  logic feat_ok, unit_ok;
  assign feat_ok = 32'(in_feat) < FEATURES;
  assign unit_ok = 32'(in_unit) < HIDDEN_UNITS;

  logic [WADDR_W-1:0] wwaddr, wraddr;
  logic [BADDR_W-1:0] bwaddr, braddr;
  assign wwaddr = WADDR_W'((int'(in_gate) * FEATURES + int'(in_feat)) * HIDDEN_UNITS
                           + int'(in_unit));
  assign bwaddr = BADDR_W'(int'(in_gate) * HIDDEN_UNITS + int'(in_unit));
  assign wraddr = WADDR_W'((int'(g_r) * FEATURES + int'(k_r)) * HIDDEN_UNITS + int'(j_r));
  assign braddr = BADDR_W'(int'(g_r) * HIDDEN_UNITS + int'(j_r));

  logic issue, is_bias;
  logic signed [16:0] xsel;
  assign issue   = (state_r == S_ISSUE);
  assign is_bias = 32'(k_r) >= FEATURES;

  always_comb begin
    xsel = 17'sd4096;   // bias term enters as bias * 2^12
    if (!is_bias) xsel = {fbuf[k_r[FIDX_W-1:0]][15], fbuf[k_r[FIDX_W-1:0]]};
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_req == REQ_WEIGHT && feat_ok && unit_ok) wmem[wwaddr] <= in_data;
    if (in_acc && in_req == REQ_BIAS && unit_ok) bmem[bwaddr] <= in_data;
    if (in_acc && in_req == REQ_FEATURE && feat_ok) fbuf[in_feat[FIDX_W-1:0]] <= in_data;
    wq_r    <= wmem[wraddr];
    bq_r    <= bmem[braddr];
    bias1_r <= is_bias;
    x1_r    <= xsel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= issue;
  end

  // chain of state cells; cell 0 holds the unit being worked on
  logic signed [15:0] h_chain [HIDDEN_UNITS+1];
  logic signed [15:0] c_chain [HIDDEN_UNITS+1];
  logic shift;

  genvar n;
  generate
    for (n = 0; n < HIDDEN_UNITS; n++) begin : g_cell
      lsc_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .h_in  (h_chain[n+1]),
        .c_in  (c_chain[n+1]),
        .h_out (h_chain[n]),
        .c_out (c_chain[n])
      );
    end
  endgenerate

  logic signed [15:0] hnew;
  assign hnew = sat16(40'((hm_r + 28'sd2048) >>> 12));
  assign h_chain[HIDDEN_UNITS] = hnew;
  assign c_chain[HIDDEN_UNITS] = cnew_r;

  mac_ctrl_t mctl;
  logic mbusy;
  logic signed [ACC_W-1:0] acc;
  assign mctl.valid = v1_r;
  assign mctl.clr   = (state_r == S_IDLE) || (state_r == S_GATE);

  lsc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mctl),
    .wdata (bias1_r ? bq_r : wq_r),
    .xmul  (x1_r),
    .scale (scale_r),
    .busy  (mbusy),
    .acc   (acc)
  );

  logic signed [ACC_W-1:0] gsum;
  logic signed [15:0] pre;
  logic signed [13:0] act;
  assign gsum = acc + $signed({{(ACC_W-27){h_chain[0][15]}}, h_chain[0], 11'd0})
              + ACC_W'(2048);
  assign pre  = sat16(40'(gsum >>> 12));
  assign act  = (g_r == GATE_CAND) ? tanh_q12(pre) : sigmoid_q12({{2{pre[15]}}, pre});

  logic signed [31:0] csum;
  assign csum = 32'(m_r) + 32'(i_r) * 32'(ct_r) + 32'sd2048;

  logic reported, out_free;
  assign reported = 32'(j_r) < REPORT;
  assign out_free = !out_tvalid_r || out_tready;
  assign shift    = (state_r == S_EMIT) && (!reported || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scale_r      <= SCALE_RESET;
      g_r          <= '0;
      k_r          <= '0;
      j_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) scale_r <= cfg_data;
      if (out_tvalid_r && out_tready && !(shift && reported)) out_tvalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          g_r <= '0;
          k_r <= '0;
          j_r <= '0;
          if (in_acc && in_req == REQ_FEATURE && in_tlast) state_r <= S_ISSUE;
        end
        S_ISSUE: begin
          if (is_bias) state_r <= S_DRAIN;
          else k_r <= k_r + 1'b1;
        end
        S_DRAIN: begin
          if (!v1_r && !mbusy) state_r <= S_GATE;
        end
        S_GATE: begin
          case (g_r)
            GATE_FORGET: f_r  <= act;
            GATE_INPUT:  i_r  <= act;
            GATE_CAND:   ct_r <= act;
            default:     o_r  <= act;
          endcase
          k_r <= '0;
          if (g_r == GATE_OUTPUT) state_r <= S_CMUL;
          else begin
            g_r     <= g_r + 1'b1;
            state_r <= S_ISSUE;
          end
        end
        S_CMUL: begin
          m_r     <= 30'(f_r) * 30'(c_chain[0]);
          state_r <= S_CADD;
        end
        S_CADD: begin
          cnew_r  <= sat16(40'(csum >>> 12));
          state_r <= S_HMUL;
        end
        S_HMUL: begin
          hm_r    <= 28'(o_r) * 28'(tanh_q12(cnew_r));
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (shift) begin
            if (reported) begin
              out_tvalid_r <= 1'b1;
              out_unit_r   <= 3'(j_r);
              out_h_r      <= hnew;
              out_c_r      <= cnew_r;
              out_tlast_r  <= (32'(j_r) == REPORT - 1);
            end
            g_r <= '0;
            k_r <= '0;
            if (32'(j_r) == HIDDEN_UNITS - 1) state_r <= S_IDLE;
            else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_ISSUE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = {5'd0, out_c_r, out_h_r, out_unit_r};
endmodule

// ===== sv/lsc_cell.sv =====
`timescale 1ns / 1ps
module lsc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift,
  input  logic signed [15:0] h_in,
  input  logic signed [15:0] c_in,
  output logic signed [15:0] h_out,
  output logic signed [15:0] c_out
);
  import lsc_pkg::*;

  logic signed [15:0] h_r, c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0;
      c_r <= '0;
    end else if (shift) begin
      h_r <= h_in;
      c_r <= c_in;
    end
  end

  assign h_out = h_r;
  assign c_out = c_r;
endmodule

// ===== sv/lsc_mac.sv =====
`timescale 1ns / 1ps
module lsc_mac (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lsc_pkg::mac_ctrl_t             ctrl,
  input  logic signed [15:0]             wdata,
  input  logic signed [16:0]             xmul,
  input  logic [15:0]                    scale,
  output logic                           busy,
  output logic signed [lsc_pkg::ACC_W-1:0] acc
);
  import lsc_pkg::*;

  logic                      v2_r, v3_r;
  logic signed [32:0]        p1_r;
  logic signed [16:0]        x2_r;
  logic signed [34:0]        p2_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [32:0]        p1_rnd;
  logic signed [17:0]        sw;

  // scaled weight: round(w * scale / 2^16)
  assign p1_rnd = p1_r + 33'sd32768;
  assign sw     = 18'(p1_rnd >>> 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      v2_r <= ctrl.valid;
      v3_r <= v2_r;
      if (ctrl.clr) acc_r <= '0;
      else if (v3_r) acc_r <= acc_r + ACC_W'(p2_r);
    end
    p1_r <= 33'(wdata) * 33'($signed({1'b0, scale}));
    x2_r <= xmul;
    p2_r <= 35'(sw) * 35'(x2_r);
  end

  assign busy = v2_r | v3_r;
  assign acc  = acc_r;
endmodule

// ===== tb/lstm_cell_checker.sv =====
`timescale 1ns / 1ps
module lstm_cell_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [3:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          fail_count
);
  import lsc_pkg::*;

  typedef struct {
    logic [2:0]  unit;
    logic [15:0] hid;
    logic [15:0] cel;
    logic        last;
  } unit_result_t;

  unit_result_t hidden_q[$];

  logic [15:0] scale;
  int weights [4*FEATURES*HIDDEN_UNITS];
  int biases  [4*HIDDEN_UNITS];
  int feats   [FEATURES];
  int hid_st  [HIDDEN_UNITS];
  int cel_st  [HIDDEN_UNITS];

  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int plan_sigmoid(int x);
    int a;
    int y;
    a = (x < 0) ? -x : x;
    if (a >= 20480) y = 4096;
    else if (a >= 9728) y = a / 32 + 3456;
    else if (a >= 4096) y = a / 8 + 2560;
    else y = a / 4 + 2048;
    return (x < 0) ? 4096 - y : y;
  endfunction

  function automatic int plan_tanh(int x);
    return 2 * plan_sigmoid(2 * x) - 4096;
  endfunction

  function automatic int gate_sum(int g, int j);
    longint acc;
    longint sw;
    acc = round_shift(longint'(biases[g*HIDDEN_UNITS+j]) * longint'(scale), 16) * 4096;
    for (int k = 0; k < FEATURES; k++) begin
      sw = round_shift(longint'(weights[(g*FEATURES+k)*HIDDEN_UNITS+j]) * longint'(scale), 16);
      acc += longint'(feats[k]) * sw;
    end
    acc += longint'(hid_st[j]) * 2048;
    return clamp16(round_shift(acc, 12));
  endfunction

  task automatic predict_step();
    int nh [HIDDEN_UNITS];
    int nc [HIDDEN_UNITS];
    int f, i, ct, o;
    unit_result_t r;
    for (int j = 0; j < HIDDEN_UNITS; j++) begin
      f  = plan_sigmoid(gate_sum(0, j));
      i  = plan_sigmoid(gate_sum(1, j));
      ct = plan_tanh(gate_sum(2, j));
      o  = plan_sigmoid(gate_sum(3, j));
      nc[j] = clamp16(round_shift(longint'(f) * cel_st[j] + longint'(i) * ct, 12));
      nh[j] = clamp16(round_shift(longint'(o) * plan_tanh(nc[j]), 12));
    end
    for (int j = 0; j < HIDDEN_UNITS; j++) begin
      hid_st[j] = nh[j];
      cel_st[j] = nc[j];
    end
    for (int j = 0; j < REPORT; j++) begin
      r.unit = 3'(j);
      r.hid  = 16'(nh[j]);
      r.cel  = 16'(nc[j]);
      r.last = (j + 1 == REPORT);
      hidden_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic apply_beat();
    logic [1:0]  req;
    logic [1:0]  gate;
    logic [2:0]  feat;
    logic [2:0]  unit;
    logic signed [15:0] val;
    req  = in_tuser[1:0];
    gate = in_tuser[3:2];
    feat = in_tdata[2:0];
    unit = in_tdata[5:3];
    val  = in_tdata[21:6];
    case (req)
      REQ_WEIGHT: begin
        if (feat < FEATURES && unit < HIDDEN_UNITS)
          weights[(gate*FEATURES+feat)*HIDDEN_UNITS+unit] = val;
      end
      REQ_BIAS: begin
        if (unit < HIDDEN_UNITS) biases[gate*HIDDEN_UNITS+unit] = val;
      end
      REQ_FEATURE: begin
        if (feat < FEATURES) feats[feat] = val;
        if (in_tlast) predict_step();
      end
      default: ;
    endcase
  endtask

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    unit_result_t e;
    if (!rst_n) begin
      scale = SCALE_RESET;
      hidden_q.delete();
      foreach (weights[n]) weights[n] = 0;
      foreach (biases[n]) biases[n] = 0;
      foreach (feats[n]) feats[n] = 0;
      foreach (hid_st[n]) hid_st[n] = 0;
      foreach (cel_st[n]) cel_st[n] = 0;
    end else begin
      if (cfg_valid && cfg_ready) scale = cfg_data;
      if (out_tvalid && out_tready) begin
        if (hidden_q.size() == 0) begin
          report_mismatch("unexpected result beat", int'(out_tdata[2:0]), 0);
        end else begin
          e = hidden_q.pop_front();
          if (out_tdata[2:0] != e.unit)
            report_mismatch("hidden_unit", out_tdata[2:0], e.unit);
          if (out_tdata[18:3] != e.hid)
            report_mismatch("hidden_out", out_tdata[18:3], e.hid);
          if (out_tdata[34:19] != e.cel)
            report_mismatch("cell_out", out_tdata[34:19], e.cel);
          if (out_tlast != e.last)
            report_mismatch("last_of_run", out_tlast, e.last);
        end
      end
      if (in_tvalid && in_tready) apply_beat();
    end
    pending <= hidden_q.size();
  end

endmodule

// ===== tb/lstm_cell_step_test.sv =====
`timescale 1ns / 1ps
module lstm_cell_step_test;
  import lsc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  int          pending;
  int          fail_count;
  int          burst_left = 0;
  int          cycle_cnt = 0;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lstm_cell_step dut (.*);

  lstm_cell_checker chk (.*);

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stall pattern, with one long hold-off while the sender keeps going
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n) out_tready <= 1'b0;
    else if (cycle_cnt >= 3000 && cycle_cnt < 4500) out_tready <= 1'b0;
    else if ((cycle_cnt / 300) % 3 == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_beat(logic [1:0] req, logic [1:0] gate, logic [2:0] feat,
                           logic [2:0] unit, logic [15:0] val, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= {gate, req};
    in_tdata  <= {2'b00, val, unit, feat};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_scale(logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_beats(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        send_beat(REQ_FEATURE, 2'($urandom), 3'($urandom), 3'($urandom), pick_value(), 1'b0);
      else if (r < 72)
        send_beat(REQ_FEATURE, 2'($urandom), 3'($urandom), 3'($urandom), pick_value(), 1'b1);
      else if (r < 86)
        send_beat(REQ_WEIGHT, 2'($urandom), 3'($urandom), 3'($urandom), pick_value(),
                  1'($urandom));
      else if (r < 95)
        send_beat(REQ_BIAS, 2'($urandom), 3'($urandom), 3'($urandom), pick_value(),
                  1'($urandom));
      else
        send_beat(REQ_UNKNOWN, 2'($urandom), 3'($urandom), 3'($urandom), pick_value(),
                  1'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every store so no step reads an unwritten entry
    for (int g = 0; g < 4; g++)
      for (int k = 0; k < FEATURES; k++)
        for (int j = 0; j < HIDDEN_UNITS; j++)
          send_beat(REQ_WEIGHT, 2'(g), 3'(k), 3'(j), pick_value(), 1'b0);
    for (int g = 0; g < 4; g++)
      for (int j = 0; j < HIDDEN_UNITS; j++)
        send_beat(REQ_BIAS, 2'(g), 3'($urandom), 3'(j), pick_value(), 1'b0);
    for (int k = 0; k < FEATURES; k++)
      send_beat(REQ_FEATURE, 2'($urandom), 3'(k), 3'($urandom), pick_value(), 1'b0);

    // directed: default, full and zero scale, extremes, ignored marks and requests
    send_beat(REQ_FEATURE, GATE_FORGET, 3'd7, 3'd0, 16'h7fff, 1'b1);
    send_beat(REQ_FEATURE, GATE_OUTPUT, 3'd0, 3'd7, 16'h8000, 1'b1);
    send_beat(REQ_WEIGHT, GATE_INPUT, 3'd3, 3'd5, 16'h7fff, 1'b1);
    send_beat(REQ_BIAS, GATE_CAND, 3'd2, 3'd7, 16'h8000, 1'b1);
    send_beat(REQ_UNKNOWN, GATE_OUTPUT, 3'd7, 3'd7, 16'hffff, 1'b1);
    send_beat(REQ_FEATURE, GATE_CAND, 3'd4, 3'd2, 16'h0000, 1'b1);
    write_scale(16'hffff);
    for (int g = 0; g < 4; g++)
      send_beat(REQ_BIAS, 2'(g), 3'd0, 3'd1, (g % 2) ? 16'h7fff : 16'h8000, 1'b0);
    send_beat(REQ_FEATURE, GATE_FORGET, 3'd1, 3'd0, 16'h7fff, 1'b1);
    send_beat(REQ_FEATURE, GATE_FORGET, 3'd1, 3'd0, 16'h8000, 1'b1);
    write_scale(16'h0000);
    send_beat(REQ_FEATURE, GATE_INPUT, 3'd5, 3'd3, 16'h1234, 1'b1);
    send_beat(REQ_FEATURE, GATE_INPUT, 3'd6, 3'd3, 16'hedcb, 1'b1);

    // random phases over several scale settings
    write_scale(16'd655);
    random_beats(30);
    write_scale(16'hffff);
    random_beats(25);
    write_scale(16'($urandom));
    random_beats(25);
    write_scale(16'd1);
    random_beats(30);

    drain();
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
